FILE: hw/rtl/gbfs_pkg.sv
`default_nettype none

package gbfs_pkg;

    localparam int PIN_COUNT_DEF = 54;
    localparam int MAX_PINS      = 64;
    localparam int WORD_BITS     = 32;
    localparam int IDX_W         = 6;
    localparam int FSEL_PINS     = 10;
    localparam int FSEL_BITS     = 3;
    localparam int FSEL_WORDS    = 6;
    localparam int PULL_W        = 2;

    localparam logic [IDX_W-1:0] REG_SET0  = 6'd7;
    localparam logic [IDX_W-1:0] REG_SET1  = 6'd8;
    localparam logic [IDX_W-1:0] REG_CLR0  = 6'd10;
    localparam logic [IDX_W-1:0] REG_CLR1  = 6'd11;
    localparam logic [IDX_W-1:0] REG_LEV0  = 6'd13;
    localparam logic [IDX_W-1:0] REG_LEV1  = 6'd14;
    localparam logic [IDX_W-1:0] REG_PULL  = 6'd37;
    localparam logic [IDX_W-1:0] REG_PCLK0 = 6'd38;
    localparam logic [IDX_W-1:0] REG_PCLK1 = 6'd39;

    localparam logic [FSEL_BITS-1:0] FUNC_OUTPUT = 3'd1;

    localparam logic [PULL_W-1:0] PULL_DOWN = 2'd1;
    localparam logic [PULL_W-1:0] PULL_UP   = 2'd2;
    localparam logic [PULL_W-1:0] PULL_RSVD = 2'd3;

    typedef struct packed {
        logic             en;
        logic             wr;
        logic [IDX_W-1:0] idx;
    } access_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gbfs_regs.sv
`default_nettype none

module gbfs_regs #(
    parameter int PIN_COUNT = gbfs_pkg::PIN_COUNT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire gbfs_pkg::access_t              acc,
    input  wire logic [gbfs_pkg::WORD_BITS-1:0] wr_data,
    input  wire logic [PIN_COUNT-1:0]           pads,
    output logic      [gbfs_pkg::WORD_BITS-1:0] rd_data,
    output logic      [PIN_COUNT-1:0]           drive_enable,
    output logic      [PIN_COUNT-1:0]           drive_level,
    output logic      [PIN_COUNT-1:0]           pull_up_mask,
    output logic      [PIN_COUNT-1:0]           pull_down_mask
);

    import gbfs_pkg::*;

    logic [FSEL_BITS-1:0] codes_reg  [PIN_COUNT];
    logic [FSEL_BITS-1:0] codes_next [PIN_COUNT];
    logic [PULL_W-1:0]    pstate_reg  [PIN_COUNT];
    logic [PULL_W-1:0]    pstate_next [PIN_COUNT];
    logic [PIN_COUNT-1:0] latch_reg;
    logic [PIN_COUNT-1:0] latch_next;
    logic [PULL_W-1:0]    pctl_reg;
    logic [PULL_W-1:0]    pctl_next;

    logic [PIN_COUNT-1:0] drv_cur;
    logic [MAX_PINS-1:0]  lvl_ext;
    logic [PIN_COUNT-1:0] spread_pins;

    function automatic logic [PIN_COUNT-1:0] spread(input logic [WORD_BITS-1:0] w,
                                                    input logic hi);
        logic [2*WORD_BITS-1:0] wide;
        wide = hi ? {w, {WORD_BITS{1'b0}}} : {{WORD_BITS{1'b0}}, w};
        return wide[PIN_COUNT-1:0];
    endfunction

    always_comb begin
        for (int p = 0; p < PIN_COUNT; p++) begin
            drv_cur[p] = (codes_reg[p] == FUNC_OUTPUT);
        end
        lvl_ext = '0;
        lvl_ext[PIN_COUNT-1:0] = (latch_reg & drv_cur) | (pads & ~drv_cur);
    end

    always_comb begin
        codes_next  = codes_reg;
        pstate_next = pstate_reg;
        latch_next  = latch_reg;
        pctl_next   = pctl_reg;
        rd_data     = '0;
        spread_pins = spread(wr_data, (acc.idx == REG_SET1) || (acc.idx == REG_CLR1)
                                      || (acc.idx == REG_PCLK1));
        if (acc.wr) begin
            if (acc.en) begin
                for (int w = 0; w < FSEL_WORDS; w++) begin
                    for (int i = 0; i < FSEL_PINS; i++) begin
                        if ((w * FSEL_PINS + i < PIN_COUNT) && (acc.idx == IDX_W'(w))) begin
                            codes_next[w * FSEL_PINS + i] = wr_data[i * FSEL_BITS +: FSEL_BITS];
                        end
                    end
                end
                unique case (acc.idx)
                    REG_SET0, REG_SET1: begin
                        latch_next = latch_reg | spread_pins;
                    end
                    REG_CLR0, REG_CLR1: begin
                        latch_next = latch_reg & ~spread_pins;
                    end
                    REG_PULL: begin
                        pctl_next = wr_data[PULL_W-1:0];
                    end
                    REG_PCLK0, REG_PCLK1: begin
                        if (pctl_reg != PULL_RSVD) begin
                            for (int p = 0; p < PIN_COUNT; p++) begin
                                if (spread_pins[p]) begin
                                    pstate_next[p] = pctl_reg;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            for (int w = 0; w < FSEL_WORDS; w++) begin
                for (int i = 0; i < FSEL_PINS; i++) begin
                    if ((w * FSEL_PINS + i < PIN_COUNT) && (acc.idx == IDX_W'(w))) begin
                        rd_data[i * FSEL_BITS +: FSEL_BITS] = codes_reg[w * FSEL_PINS + i];
                    end
                end
            end
            unique case (acc.idx)
                REG_LEV0: begin
                    rd_data = lvl_ext[WORD_BITS-1:0];
                end
                REG_LEV1: begin
                    rd_data = lvl_ext[2*WORD_BITS-1:WORD_BITS];
                end
                REG_PULL: begin
                    rd_data = WORD_BITS'(pctl_reg);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int p = 0; p < PIN_COUNT; p++) begin
            drive_enable[p]   = (codes_next[p] == FUNC_OUTPUT);
            pull_up_mask[p]   = (pstate_next[p] == PULL_UP);
            pull_down_mask[p] = (pstate_next[p] == PULL_DOWN);
        end
        drive_level = latch_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PIN_COUNT; p++) begin
                codes_reg[p]  <= '0;
                pstate_reg[p] <= '0;
            end
            latch_reg <= '0;
            pctl_reg  <= '0;
        end else begin
            codes_reg  <= codes_next;
            pstate_reg <= pstate_next;
            latch_reg  <= latch_next;
            pctl_reg   <= pctl_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gpio_bank_with_function_select.sv
// GPIO register bank with function select, set/clear output latches, level
// read and a clocked pull control.
// Each item on the slave channel is one access to a 32-bit word of the bank:
// tuser carries the access kind (0 read, 1 write), tdata the word offset,
// the write data and the external pad levels. Each accepted item produces
// exactly one item on the master channel with the word read (zero for a
// write) and the drive enable, drive level and pull masks of all pins as
// they stand after the access.
// An item passes an input register and then a result register, and its
// result is presented from the result register. One item is accepted in
// every cycle while the master side keeps up; the single decode and
// masked update between the two registers sets this rate.
// Reset clears every function code to input, the output latches, the pull
// control and every pull state, and empties both registers.
// When the receiver stalls, the result is held and one further item is
// taken into the input register; after that tready falls until the
// result is taken.
`default_nettype none

module gpio_bank_with_function_select #(
    parameter int PIN_COUNT = gbfs_pkg::PIN_COUNT_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // reg_index, write_data, pad_levels
    input  wire logic [((gbfs_pkg::IDX_W + gbfs_pkg::WORD_BITS + PIN_COUNT + 7) / 8) * 8 - 1:0]
                      s_axis_tdata,
    // req_type
    input  wire logic s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // read_data, drive_enable, drive_level, pull_up_mask, pull_down_mask
    output logic      [((gbfs_pkg::WORD_BITS + 4 * PIN_COUNT + 7) / 8) * 8 - 1:0]
                      m_axis_tdata
);

    import gbfs_pkg::*;

    localparam int OUT_W   = ((WORD_BITS + 4 * PIN_COUNT + 7) / 8) * 8;
    localparam int DATA_LO = IDX_W;
    localparam int PAD_LO  = IDX_W + WORD_BITS;

    logic                 s_accept;
    logic                 advance;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 in_wr_reg;
    logic [IDX_W-1:0]     in_idx_reg;
    logic [WORD_BITS-1:0] in_data_reg;
    logic [PIN_COUNT-1:0] in_pads_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    access_t              acc;
    logic [WORD_BITS-1:0] rd_data;
    logic [PIN_COUNT-1:0] drive_enable;
    logic [PIN_COUNT-1:0] drive_level;
    logic [PIN_COUNT-1:0] pull_up_mask;
    logic [PIN_COUNT-1:0] pull_down_mask;

    logic [WORD_BITS-1:0] rd_data_reg;
    logic [PIN_COUNT-1:0] drive_enable_reg;
    logic [PIN_COUNT-1:0] drive_level_reg;
    logic [PIN_COUNT-1:0] pull_up_reg;
    logic [PIN_COUNT-1:0] pull_down_reg;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    assign acc.en  = advance;
    assign acc.wr  = in_wr_reg;
    assign acc.idx = in_idx_reg;

    gbfs_regs #(
        .PIN_COUNT(PIN_COUNT)
    ) u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .acc           (acc),
        .wr_data       (in_data_reg),
        .pads          (in_pads_reg),
        .rd_data       (rd_data),
        .drive_enable  (drive_enable),
        .drive_level   (drive_level),
        .pull_up_mask  (pull_up_mask),
        .pull_down_mask(pull_down_mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_wr_reg   <= s_axis_tuser;
            in_idx_reg  <= s_axis_tdata[IDX_W-1:0];
            in_data_reg <= s_axis_tdata[DATA_LO +: WORD_BITS];
            in_pads_reg <= s_axis_tdata[PAD_LO +: PIN_COUNT];
        end
        if (advance) begin
            rd_data_reg      <= rd_data;
            drive_enable_reg <= drive_enable;
            drive_level_reg  <= drive_level;
            pull_up_reg      <= pull_up_mask;
            pull_down_reg    <= pull_down_mask;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({pull_down_reg, pull_up_reg, drive_level_reg,
                                   drive_enable_reg, rd_data_reg});

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import gbfs_pkg::*;

    localparam int PINS = PIN_COUNT_DEF;
    localparam int S_W = ((IDX_W + WORD_BITS + PINS + 7) / 8) * 8;
    localparam int M_W = ((WORD_BITS + 4 * PINS + 7) / 8) * 8;
    localparam logic ACC_READ = 1'b0;
    localparam logic ACC_WRITE = 1'b1;
    localparam logic [IDX_W-1:0] REG_FSEL0 = 6'd0;
    localparam logic [IDX_W-1:0] REG_FSEL3 = 6'd3;
    localparam logic [IDX_W-1:0] REG_FSEL5 = 6'd5;
    localparam logic [IDX_W-1:0] REG_GAP6 = 6'd6;
    localparam logic [IDX_W-1:0] REG_GAP12 = 6'd12;
    localparam logic [IDX_W-1:0] REG_LAST = 6'd63;
    localparam logic [WORD_BITS-1:0] ALL_OUTPUT = 32'h0924_9249;
    localparam logic [PINS-1:0] PADS_LOW = '0;
    localparam logic [PINS-1:0] PADS_HIGH = '1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [WORD_BITS-1:0] rd;
        logic [PINS-1:0] drive_en;
        logic [PINS-1:0] drive_lvl;
        logic [PINS-1:0] pull_up;
        logic [PINS-1:0] pull_down;
    } gpio_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_W-1:0] m_axis_tdata;

    logic [FSEL_BITS-1:0] pin_func [PINS];
    logic [PINS-1:0] out_latch;
    logic [PULL_W-1:0] pull_ctl;
    logic [PULL_W-1:0] pin_pull [PINS];

    gpio_result_t pending_results [$];
    gpio_result_t want;
    int mismatch_count = 0;
    int cycle_count = 0;
    int tx_idle_pct = 37;
    int rx_idle_pct = 37;
    bit hold_request = 1'b0;
    int hold_left = 0;

    gpio_bank_with_function_select uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic gpio_result_t predict_access(input logic wr,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [WORD_BITS-1:0] data,
                                                    input logic [PINS-1:0] pads);
        gpio_result_t r;
        logic [MAX_PINS-1:0] sel;
        logic [MAX_PINS-1:0] lvl;
        logic [PINS-1:0] drv;
        int half;
        int p;
        r = '0;
        half = (idx == REG_SET1 || idx == REG_CLR1 || idx == REG_LEV1 || idx == REG_PCLK1)
               ? 1 : 0;
        sel = {{(MAX_PINS-WORD_BITS){1'b0}}, data} << (WORD_BITS * half);
        for (int i = 0; i < PINS; i++) begin
            drv[i] = (pin_func[i] == FUNC_OUTPUT);
        end
        if (wr == ACC_WRITE) begin
            if (idx < FSEL_WORDS) begin
                for (int i = 0; i < FSEL_PINS; i++) begin
                    p = int'(idx) * FSEL_PINS + i;
                    if (p < PINS) begin
                        pin_func[p] = data[i*FSEL_BITS +: FSEL_BITS];
                    end
                end
            end else begin
                case (idx)
                    REG_SET0, REG_SET1: begin
                        out_latch = out_latch | sel[PINS-1:0];
                    end
                    REG_CLR0, REG_CLR1: begin
                        out_latch = out_latch & ~sel[PINS-1:0];
                    end
                    REG_PULL: begin
                        pull_ctl = data[PULL_W-1:0];
                    end
                    REG_PCLK0, REG_PCLK1: begin
                        if (pull_ctl != PULL_RSVD) begin
                            for (int i = 0; i < PINS; i++) begin
                                if (sel[i]) begin
                                    pin_pull[i] = pull_ctl;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end else begin
            if (idx < FSEL_WORDS) begin
                for (int i = 0; i < FSEL_PINS; i++) begin
                    p = int'(idx) * FSEL_PINS + i;
                    if (p < PINS) begin
                        r.rd[i*FSEL_BITS +: FSEL_BITS] = pin_func[p];
                    end
                end
            end else if (idx == REG_LEV0 || idx == REG_LEV1) begin
                lvl = {{(MAX_PINS-PINS){1'b0}}, (out_latch & drv) | (pads & ~drv)};
                r.rd = lvl[half*WORD_BITS +: WORD_BITS];
            end else if (idx == REG_PULL) begin
                r.rd = {{(WORD_BITS-PULL_W){1'b0}}, pull_ctl};
            end
        end
        for (int i = 0; i < PINS; i++) begin
            r.drive_en[i] = (pin_func[i] == FUNC_OUTPUT);
            r.pull_up[i] = (pin_pull[i] == PULL_UP);
            r.pull_down[i] = (pin_pull[i] == PULL_DOWN);
        end
        r.drive_lvl = out_latch;
        return r;
    endfunction

    // Entered and left at a falling edge; tvalid stays high between items
    // unless the sender chooses to idle.
    task automatic send_access(input logic wr, input logic [IDX_W-1:0] idx,
                               input logic [WORD_BITS-1:0] data,
                               input logic [PINS-1:0] pads);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= wr;
        s_axis_tdata <= S_W'({pads, data, idx});
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_results.push_back(predict_access(wr, idx, data, pads));
        @(negedge aclk);
    endtask

    task automatic send_random_access();
        logic [IDX_W-1:0] idx;
        logic [WORD_BITS-1:0] data;
        logic [PINS-1:0] pads;
        logic wr;
        int pick;
        wr = 1'($urandom_range(1));
        pads = PINS'({$urandom, $urandom});
        data = $urandom;
        pick = $urandom_range(99);
        if (pick < 25) begin
            idx = IDX_W'($urandom_range(FSEL_WORDS - 1));
            for (int i = 0; i < FSEL_PINS; i++) begin
                case ($urandom_range(3))
                    0, 1: data[i*FSEL_BITS +: FSEL_BITS] = FUNC_OUTPUT;
                    2: data[i*FSEL_BITS +: FSEL_BITS] = '0;
                    default: ;
                endcase
            end
        end else if (pick < 85) begin
            case ($urandom_range(9))
                0: idx = REG_SET0;
                1: idx = REG_SET1;
                2: idx = REG_CLR0;
                3: idx = REG_CLR1;
                4: idx = REG_LEV0;
                5: idx = REG_LEV1;
                6, 7: idx = REG_PULL;
                8: idx = REG_PCLK0;
                default: idx = REG_PCLK1;
            endcase
        end else begin
            idx = IDX_W'($urandom_range(63));
        end
        send_access(wr, idx, data, pads);
    endtask

    task automatic test_function_select();
        send_access(ACC_READ, REG_FSEL0, '0, PADS_LOW);
        send_access(ACC_WRITE, REG_FSEL0, 32'hFFFF_FFFF, PADS_HIGH);
        send_access(ACC_READ, REG_FSEL0, '0, PADS_LOW);
        send_access(ACC_WRITE, REG_FSEL0, ALL_OUTPUT, PADS_LOW);
        send_access(ACC_WRITE, REG_FSEL3, ALL_OUTPUT, PADS_LOW);
        send_access(ACC_WRITE, REG_FSEL5, 32'hFFFF_FFFF, PADS_LOW);
        send_access(ACC_READ, REG_FSEL5, '0, PADS_HIGH);
        send_access(ACC_WRITE, REG_FSEL5, ALL_OUTPUT, PADS_LOW);
    endtask

    task automatic test_set_clear_level();
        send_access(ACC_WRITE, REG_SET0, 32'hFFFF_FFFF, PADS_LOW);
        send_access(ACC_WRITE, REG_SET1, 32'hFFFF_FFFF, PADS_LOW);
        send_access(ACC_READ, REG_LEV0, '0, PADS_LOW);
        send_access(ACC_READ, REG_LEV1, '0, PADS_HIGH);
        send_access(ACC_WRITE, REG_CLR0, 32'h5555_5555, PADS_LOW);
        send_access(ACC_WRITE, REG_CLR1, 32'hFFFF_FFFF, PADS_LOW);
        send_access(ACC_READ, REG_LEV0, '0, PADS_HIGH);
        send_access(ACC_WRITE, REG_LEV1, 32'hFFFF_FFFF, PADS_HIGH);
        send_access(ACC_READ, REG_SET0, '0, PADS_HIGH);
    endtask

    task automatic test_pull_control();
        send_access(ACC_WRITE, REG_PULL, 32'hFFFF_FFFE, PADS_LOW);
        send_access(ACC_WRITE, REG_PCLK0, 32'hFFFF_FFFF, PADS_LOW);
        send_access(ACC_WRITE, REG_PULL, WORD_BITS'(PULL_DOWN), PADS_LOW);
        send_access(ACC_WRITE, REG_PCLK1, 32'hFFFF_FFFF, PADS_LOW);
        send_access(ACC_WRITE, REG_PULL, WORD_BITS'(PULL_RSVD), PADS_LOW);
        send_access(ACC_WRITE, REG_PCLK0, 32'hFFFF_FFFF, PADS_LOW);
        send_access(ACC_READ, REG_PULL, '0, PADS_LOW);
        send_access(ACC_READ, REG_PCLK1, '0, PADS_LOW);
        send_access(ACC_WRITE, REG_PULL, '0, PADS_LOW);
        send_access(ACC_WRITE, REG_PCLK0, 32'h0000_FFFF, PADS_LOW);
    endtask

    task automatic test_reserved_offsets();
        send_access(ACC_WRITE, REG_GAP6, 32'hFFFF_FFFF, PADS_HIGH);
        send_access(ACC_READ, REG_GAP6, '0, PADS_HIGH);
        send_access(ACC_WRITE, REG_LAST, 32'hFFFF_FFFF, PADS_HIGH);
        send_access(ACC_READ, REG_LAST, '0, PADS_HIGH);
        send_access(ACC_READ, REG_GAP12, '0, PADS_HIGH);
    endtask

    task automatic test_random_accesses(input int count);
        repeat (count) send_random_access();
    endtask

    task automatic test_back_to_back();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (60) send_random_access();
        tx_idle_pct = 37;
        rx_idle_pct = 37;
    endtask

    task automatic test_receiver_hold_off();
        tx_idle_pct = 0;
        hold_request = 1'b1;
        repeat (40) send_random_access();
        tx_idle_pct = 37;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            mismatch_count++;
            $display("%0t: %s expected %h, actual %h", $time, name, exp_val, act_val);
        end
    endtask

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("read_data", 64'(want.rd), 64'(m_axis_tdata[0 +: WORD_BITS]));
                check_field("drive_enable", 64'(want.drive_en),
                            64'(m_axis_tdata[WORD_BITS +: PINS]));
                check_field("drive_level", 64'(want.drive_lvl),
                            64'(m_axis_tdata[WORD_BITS + PINS +: PINS]));
                check_field("pull_up_mask", 64'(want.pull_up),
                            64'(m_axis_tdata[WORD_BITS + 2 * PINS +: PINS]));
                check_field("pull_down_mask", 64'(want.pull_down),
                            64'(m_axis_tdata[WORD_BITS + 3 * PINS +: PINS]));
            end
        end
    end

    initial begin
        for (int i = 0; i < PINS; i++) begin
            pin_func[i] = '0;
            pin_pull[i] = '0;
        end
        out_latch = '0;
        pull_ctl = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_function_select();
        test_set_clear_level();
        test_pull_control();
        test_reserved_offsets();
        test_random_accesses(450);
        test_back_to_back();
        test_receiver_hold_off();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
